// ===== rtl/scd_pkg.sv =====
// ============================================================================
// scd_pkg
// Types, constants and day tables shared by the seconds-to-date converter.
// ============================================================================
package scd_pkg;

    // Pipeline depth: input register, four arithmetic stages, result register
    localparam int unsigned STAGES = 6;
    typedef logic [STAGES-1:0] t_stage_vec;

    // Field and internal widths
    localparam int unsigned SEC_W   = 31;  // seconds count
    localparam int unsigned DAYS_W  = 15;  // whole days, < 24856
    localparam int unsigned SOD_W   = 17;  // second of day, < 86400
    localparam int unsigned MOD_W   = 11;  // minute of day, < 1440
    localparam int unsigned CYC_W   = 5;   // four-year cycles, < 18
    localparam int unsigned REM_W   = 11;  // day within a four-year period, < 1461
    localparam int unsigned DOY_W   = 9;   // day within a year, < 366
    localparam int unsigned YOFF_W  = 2;   // year within a four-year period
    localparam int unsigned YEAR_W  = 12;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned HOUR_W  = 5;
    localparam int unsigned MIN_W   = 6;

    // days = (t >> 7) / 675, exact by reciprocal for a 24-bit dividend
    localparam int unsigned DAY_SHIFT  = 7;
    localparam int unsigned DAY_HI_W   = SEC_W - DAY_SHIFT;
    localparam int unsigned DAY_RCP_W  = 25;
    localparam int unsigned DAY_PROD_W = DAY_HI_W + DAY_RCP_W;
    localparam int unsigned DAY_RCP_SH = 34;
    localparam logic [DAY_RCP_W-1:0] DAY_RECIP = 25'd25451659;
    localparam logic [SEC_W-1:0]     SEC_PER_DAY = 31'd86400;

    // cycles = days / 1461
    localparam int unsigned CYC_RCP_W  = 16;
    localparam int unsigned CYC_PROD_W = DAYS_W + CYC_RCP_W;
    localparam int unsigned CYC_RCP_SH = 26;
    localparam logic [CYC_RCP_W-1:0] CYC_RECIP  = 16'd45934;
    localparam logic [DAYS_W-1:0]    CYCLE_DAYS = 15'd1461;

    // hour = sod / 3600, minute of day = sod / 60
    localparam int unsigned TOD_RCP_W  = 18;
    localparam int unsigned TOD_PROD_W = SOD_W + TOD_RCP_W;
    localparam int unsigned HOUR_RCP_SH = 29;
    localparam int unsigned MOD_RCP_SH  = 23;
    localparam logic [TOD_RCP_W-1:0] HOUR_RECIP = 18'd149131;
    localparam logic [TOD_RCP_W-1:0] MOD_RECIP  = 18'd139811;
    localparam logic [MOD_W-1:0]     MIN_PER_HOUR = 11'd60;
    localparam logic [SOD_W-1:0]     SEC_PER_MIN  = 17'd60;

    // Calendar constants
    localparam logic [REM_W-1:0]   YEAR_DAYS   = 11'd365;
    localparam logic [REM_W-1:0]   LAST_DAY    = 11'd1460;
    localparam logic [YEAR_W-1:0]  EPOCH_YEAR  = 12'd2009;
    localparam logic [YOFF_W-1:0]  LEAP_POS    = 2'b11;
    localparam logic [MONTH_W-1:0] MONTH_DEC   = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_LAST    = 5'd31;
    localparam int unsigned        MONTHS      = 12;

    typedef struct packed {
        logic [SEC_W-1:0] seconds_count;
    } t_scd_in;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [MIN_W-1:0]   second;
    } t_scd_out;

    // Days before the first of month idx (0 = January)
    function automatic logic [DOY_W-1:0] cum_days(input logic leap,
                                                   input logic [MONTH_W-1:0] idx);
        logic [DOY_W-1:0] base;
        logic [DOY_W-1:0] adj;
        unique case (idx)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        // February 29 shifts every month after February
        adj = (leap && idx >= 4'd2) ? 9'd1 : 9'd0;
        return base + adj;
    endfunction

endpackage

// ===== rtl/scd_stream_if.sv =====
// ============================================================================
// scd_stream_if
// Valid/ready channel carrying one payload item per transfer.
// ============================================================================
interface scd_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/scd_day_div.sv =====
// ============================================================================
// scd_day_div
// Split the seconds count into whole days, second of day and 4-year cycles.
// ============================================================================
module scd_day_div
    import scd_pkg::*;
(
    input  logic               i_clk,
    input  t_stage_vec         i_en,
    input  logic [SEC_W-1:0]   i_sec,
    output logic [DAYS_W-1:0]  o_days,
    output logic [SOD_W-1:0]   o_sod,
    output logic [CYC_W-1:0]   o_cycles
);

    logic [DAYS_W-1:0]     r_s1_days;
    logic [SEC_W-1:0]      r_s1_sec;
    logic [DAYS_W-1:0]     r_s2_days;
    logic [SOD_W-1:0]      r_s2_sod;
    logic [CYC_W-1:0]      r_s2_cycles;

    logic [DAY_PROD_W-1:0] w_day_prod;
    logic [SEC_W-1:0]      w_day_sec;
    logic [SEC_W-1:0]      w_sod_full;
    logic [CYC_PROD_W-1:0] w_cyc_prod;
    logic [DAYS_W-1:0]     n_s1_days;
    logic [SOD_W-1:0]      n_s2_sod;
    logic [CYC_W-1:0]      n_s2_cycles;

    // Stage 1: 86400 = 128 * 675, shift then multiply by the reciprocal of 675
    assign w_day_prod = DAY_PROD_W'(i_sec[SEC_W-1:DAY_SHIFT]) * DAY_PROD_W'(DAY_RECIP);
    assign n_s1_days  = w_day_prod[DAY_RCP_SH +: DAYS_W];

    // Stage 2: remainder seconds and cycle count
    assign w_day_sec   = SEC_W'(r_s1_days) * SEC_PER_DAY;
    assign w_sod_full  = r_s1_sec - w_day_sec;
    assign n_s2_sod    = w_sod_full[SOD_W-1:0];
    assign w_cyc_prod  = CYC_PROD_W'(r_s1_days) * CYC_PROD_W'(CYC_RECIP);
    assign n_s2_cycles = w_cyc_prod[CYC_RCP_SH +: CYC_W];

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_s1_days <= n_s1_days;
            r_s1_sec  <= i_sec;
        end
        if (i_en[2]) begin
            r_s2_days   <= r_s1_days;
            r_s2_sod    <= n_s2_sod;
            r_s2_cycles <= n_s2_cycles;
        end
    end

    assign o_days   = r_s2_days;
    assign o_sod    = r_s2_sod;
    assign o_cycles = r_s2_cycles;

endmodule

// ===== rtl/scd_tod_split.sv =====
// ============================================================================
// scd_tod_split
// Split the second of day into hour, minute and second.
// ============================================================================
module scd_tod_split
    import scd_pkg::*;
(
    input  logic              i_clk,
    input  t_stage_vec        i_en,
    input  logic [SOD_W-1:0]  i_sod,
    output logic [HOUR_W-1:0] o_hour,
    output logic [MIN_W-1:0]  o_minute,
    output logic [MIN_W-1:0]  o_second
);

    logic [SOD_W-1:0]      r_s3_sod;
    logic [HOUR_W-1:0]     r_s3_hour;
    logic [MOD_W-1:0]      r_s3_mod;
    logic [HOUR_W-1:0]     r_s4_hour;
    logic [MIN_W-1:0]      r_s4_minute;
    logic [MIN_W-1:0]      r_s4_second;

    logic [TOD_PROD_W-1:0] w_hour_prod;
    logic [TOD_PROD_W-1:0] w_mod_prod;
    logic [MOD_W-1:0]      w_min_full;
    logic [SOD_W-1:0]      w_sec_full;

    // Stage 3: hour and minute of day by reciprocal multiply
    assign w_hour_prod = TOD_PROD_W'(i_sod) * TOD_PROD_W'(HOUR_RECIP);
    assign w_mod_prod  = TOD_PROD_W'(i_sod) * TOD_PROD_W'(MOD_RECIP);

    // Stage 4: remainders
    assign w_min_full = r_s3_mod - MOD_W'(r_s3_hour) * MIN_PER_HOUR;
    assign w_sec_full = r_s3_sod - SOD_W'(r_s3_mod) * SEC_PER_MIN;

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_s3_sod  <= i_sod;
            r_s3_hour <= w_hour_prod[HOUR_RCP_SH +: HOUR_W];
            r_s3_mod  <= w_mod_prod[MOD_RCP_SH +: MOD_W];
        end
        if (i_en[4]) begin
            r_s4_hour   <= r_s3_hour;
            r_s4_minute <= w_min_full[MIN_W-1:0];
            r_s4_second <= w_sec_full[MIN_W-1:0];
        end
    end

    assign o_hour   = r_s4_hour;
    assign o_minute = r_s4_minute;
    assign o_second = r_s4_second;

endmodule

// ===== rtl/scd_date_split.sv =====
// ============================================================================
// scd_date_split
// Turn day count and cycle count into year, month and day of month.
// ============================================================================
module scd_date_split
    import scd_pkg::*;
(
    input  logic               i_clk,
    input  t_stage_vec         i_en,
    input  logic [DAYS_W-1:0]  i_days,
    input  logic [CYC_W-1:0]   i_cycles,
    output logic [YEAR_W-1:0]  o_year,
    output logic [MONTH_W-1:0] o_month,
    output logic [DAY_W-1:0]   o_day
);

    logic [REM_W-1:0]   r_s3_rem;
    logic [CYC_W-1:0]   r_s3_cycles;
    logic [CYC_W-1:0]   r_s4_cycles;
    logic [YOFF_W-1:0]  r_s4_yoff;
    logic [DOY_W-1:0]   r_s4_doy;
    logic               r_s4_last;

    logic [DAYS_W-1:0]  w_rem_full;
    logic [YOFF_W-1:0]  w_yoff;
    logic [REM_W-1:0]   w_doy_full;
    logic               w_leap;
    logic [MONTH_W-1:0] w_idx;
    logic [DOY_W-1:0]   w_day_full;

    // Stage 3: day within the cycle
    assign w_rem_full = i_days - DAYS_W'(i_cycles) * CYCLE_DAYS;

    // Stage 4: year within the cycle and day within the year
    always_comb begin
        w_yoff = '0;
        if (r_s3_rem >= YEAR_DAYS)          w_yoff = 2'd1;
        if (r_s3_rem >= YEAR_DAYS * 11'd2)  w_yoff = 2'd2;
        if (r_s3_rem >= YEAR_DAYS * 11'd3)  w_yoff = 2'd3;
    end
    assign w_doy_full = r_s3_rem - REM_W'(w_yoff) * YEAR_DAYS;

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_s3_rem    <= w_rem_full[REM_W-1:0];
            r_s3_cycles <= i_cycles;
        end
        if (i_en[4]) begin
            r_s4_cycles <= r_s3_cycles;
            r_s4_yoff   <= w_yoff;
            r_s4_doy    <= w_doy_full[DOY_W-1:0];
            r_s4_last   <= (r_s3_rem == LAST_DAY);
        end
    end

    // Month search: count table entries at or below the day of year
    assign w_leap = ((r_s4_yoff & LEAP_POS) == LEAP_POS);

    always_comb begin
        w_idx = '0;
        for (int i = 1; i < MONTHS; i++) begin
            if (r_s4_doy >= cum_days(w_leap, MONTH_W'(i))) begin
                w_idx = w_idx + 4'd1;
            end
        end
    end

    assign w_day_full = r_s4_doy - cum_days(w_leap, w_idx) + 9'd1;

    // The year offset is already three on the last day of a cycle
    assign o_year  = EPOCH_YEAR + YEAR_W'({r_s4_cycles, r_s4_yoff});
    assign o_month = r_s4_last ? MONTH_DEC : w_idx + 4'd1;
    assign o_day   = r_s4_last ? DAY_LAST  : w_day_full[DAY_W-1:0];

endmodule

// ===== rtl/seconds_to_calendar_date.sv =====
// ============================================================================
// seconds_to_calendar_date
// Converts a seconds count since 2009-01-01 00:00:00 into year, month, day,
// hour, minute and second. The block is a six-register pipeline (input
// register, four arithmetic stages, result register) and takes one transfer
// per clock while the output is not stalled. Every division is by a constant:
// days, cycles, hours and minutes by reciprocal multiply, year and month by
// comparison, with at most one multiplier on any path between two registers,
// so the multiplier stages set the clock. Each stage has its own valid bit
// and moves on when the stage after it is empty or moving, so bubbles close
// up and input is still taken while a result waits at the output. Leap years
// are every fourth year from 2012, with no century rule; inputs up to
// 2^31-1 reach the year 2077. The last day of a leap year is forced to
// December 31. There is no state between items and nothing to configure.
// ============================================================================
module seconds_to_calendar_date
    import scd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    scd_stream_if.sink   i_sec,
    scd_stream_if.source o_date
);

    t_stage_vec        r_vld;
    t_stage_vec        n_vld;
    t_stage_vec        w_rdy;

    logic [SEC_W-1:0]  r_s0_sec;
    t_scd_out          r_out;
    t_scd_out          n_out;

    logic [DAYS_W-1:0]  w_days;
    logic [SOD_W-1:0]   w_sod;
    logic [CYC_W-1:0]   w_cycles;
    logic [HOUR_W-1:0]  w_hour;
    logic [MIN_W-1:0]   w_minute;
    logic [MIN_W-1:0]   w_second;
    logic [YEAR_W-1:0]  w_year;
    logic [MONTH_W-1:0] w_month;
    logic [DAY_W-1:0]   w_day;

    // A stage may load when it is empty or its contents advance this cycle
    always_comb begin
        w_rdy[STAGES-1] = !r_vld[STAGES-1] || o_date.ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    // Advance valid bits; a stage that loads takes the valid of the one before
    always_comb begin
        n_vld = r_vld;
        if (w_rdy[0]) begin
            n_vld[0] = i_sec.valid;
        end
        for (int k = 1; k < STAGES; k++) begin
            if (w_rdy[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Capture the input transfer
    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_s0_sec <= i_sec.data.seconds_count;
        end
    end

    // Days, second of day and cycle count (stages 1 and 2)
    scd_day_div u_day_div (
        .i_clk    (i_clk),
        .i_en     (w_rdy),
        .i_sec    (r_s0_sec),
        .o_days   (w_days),
        .o_sod    (w_sod),
        .o_cycles (w_cycles)
    );

    // Hour, minute and second (stages 3 and 4)
    scd_tod_split u_tod_split (
        .i_clk    (i_clk),
        .i_en     (w_rdy),
        .i_sod    (w_sod),
        .o_hour   (w_hour),
        .o_minute (w_minute),
        .o_second (w_second)
    );

    // Year, month and day (stages 3 and 4, month search feeds the result)
    scd_date_split u_date_split (
        .i_clk    (i_clk),
        .i_en     (w_rdy),
        .i_days   (w_days),
        .i_cycles (w_cycles),
        .o_year   (w_year),
        .o_month  (w_month),
        .o_day    (w_day)
    );

    // Result register: hold while the output transfer is stalled
    always_comb begin
        n_out.year   = w_year;
        n_out.month  = w_month;
        n_out.day    = w_day;
        n_out.hour   = w_hour;
        n_out.minute = w_minute;
        n_out.second = w_second;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[STAGES-1]) begin
            r_out <= n_out;
        end
    end

    assign i_sec.ready  = w_rdy[0];
    assign o_date.valid = r_vld[STAGES-1];
    assign o_date.data  = r_out;

endmodule

// ===== tb/seconds_to_calendar_date_tb.sv =====
// ============================================================================
// seconds_to_calendar_date_tb
// Self-checking bench for the seconds-to-date converter. A predictor turns
// every accepted seconds count into the expected calendar date; a monitor
// pops the oldest expected date for each output transfer and compares it
// field by field. Directed counts hit the rollovers and the leap-year corners.
// Random traffic follows with bursts of idling on both channels, a long
// output stall, random calendar corners and a back-to-back finish.
// ============================================================================
module seconds_to_calendar_date_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import scd_pkg::*;

    // Give up well past the slowest legal run: ~1800 transfers, each with a
    // full sender gap, a full receiver stall and the pipeline depth, plus the
    // long hold-off and the drains between tests.
    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned SETTLE_CYCLES = 3 * STAGES;
    localparam int unsigned HOLD_OFF_CYCLES = 200;
    localparam int unsigned MAX_PRINTED = 40;

    // Largest count that fits the 31-bit input
    localparam logic [SEC_W-1:0] MAX_SECONDS = '1;
    // Last cycle that still fits the input range in full
    localparam int unsigned LAST_FULL_CYCLE = 16;

    // Cumulative days before the first of each month: [leap][month index]
    localparam int unsigned MONTH_START [2][12] = '{
        '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334},
        '{0, 31, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335}
    };

    typedef struct {
        logic [SEC_W-1:0] secs;
        t_scd_out         date;
    } t_date_check;

    logic i_clk = 1'b0;
    logic i_rst_n;

    scd_stream_if #(.T(t_scd_in))  sec_if ();
    scd_stream_if #(.T(t_scd_out)) date_if ();

    seconds_to_calendar_date dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sec   (sec_if),
        .o_date  (date_if)
    );

    // Dates still owed by the block, oldest first
    t_date_check expected_dates[$];

    int unsigned mismatches = 0;
    int unsigned n_sent = 0;
    int unsigned n_checked = 0;
    int unsigned n_leap_year_end = 0;
    int unsigned n_feb29 = 0;
    int unsigned cycles_run = 0;

    // Idling switches and the one-shot hold-off request for the receiver
    bit src_idle_en = 1'b1;
    bit sink_idle_en = 1'b1;
    int unsigned stall_request = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Convert a seconds count into the calendar date the block should produce.
    function automatic t_scd_out predict_date(input logic [SEC_W-1:0] secs);
        t_scd_out                d;
        logic [25:0]             total_min;
        logic [19:0]             total_hr;
        logic [DAYS_W-1:0]       days;
        logic [CYC_W-1:0]        cycles;
        logic [REM_W-1:0]        day_in_cycle;
        logic [YOFF_W-1:0]       yoff;
        logic [DOY_W-1:0]        doy;
        logic                    leap;
        int unsigned             midx;

        d.second  = MIN_W'(secs % 60);
        total_min = 26'(secs / 60);
        d.minute  = MIN_W'(total_min % 60);
        total_hr  = 20'(total_min / 60);
        d.hour    = HOUR_W'(total_hr % 24);
        days      = DAYS_W'(total_hr / 24);

        cycles       = CYC_W'(days / CYCLE_DAYS);
        day_in_cycle = REM_W'(days % CYCLE_DAYS);

        if (day_in_cycle == LAST_DAY) begin
            // 366th day of the leap year: a plain division by 365 would spill
            // into a fifth year, so pin it to December 31
            d.year  = EPOCH_YEAR + YEAR_W'({cycles, LEAP_POS});
            d.month = MONTH_DEC;
            d.day   = DAY_LAST;
        end else begin
            yoff = YOFF_W'(day_in_cycle / YEAR_DAYS);
            doy  = DOY_W'(day_in_cycle % YEAR_DAYS);
            leap = (yoff == LEAP_POS);
            midx = 0;
            for (int m = 1; m < MONTHS; m++) begin
                if (doy >= MONTH_START[leap][m]) begin
                    midx = m;
                end
            end
            d.year  = EPOCH_YEAR + YEAR_W'({cycles, yoff});
            d.month = MONTH_W'(midx + 1);
            d.day   = DAY_W'(doy - MONTH_START[leap][midx] + 1);
        end
        return d;
    endfunction

    // Seconds count for a given day number and second of that day
    function automatic logic [SEC_W-1:0] day_secs(input int unsigned days,
                                                  input int unsigned sod);
        return SEC_W'(longint'(days) * SEC_PER_DAY + sod);
    endfunction

    // Random count that lands on or next to a month boundary or a cycle end
    function automatic logic [SEC_W-1:0] edge_seconds();
        int unsigned cyc;
        int unsigned yoff;
        int unsigned m;
        int unsigned day;
        int unsigned sod;

        cyc  = $urandom_range(0, LAST_FULL_CYCLE);
        yoff = $urandom_range(0, 3);
        m    = $urandom_range(0, MONTHS - 1);
        day  = yoff * YEAR_DAYS + MONTH_START[yoff == LEAP_POS][m];
        case ($urandom_range(0, 4))
            0: day = (day > 0) ? day - 1 : day;
            1: day = day + 1;
            2: day = LAST_DAY - $urandom_range(0, 1);
            default: ;
        endcase
        case ($urandom_range(0, 2))
            0: sod = 0;
            1: sod = SEC_PER_DAY - 1;
            default: sod = $urandom_range(0, SEC_PER_DAY - 1);
        endcase
        return day_secs(cyc * CYCLE_DAYS + day, sod);
    endfunction

    // Mix of full-range counts, calendar corners and the top of the range
    function automatic logic [SEC_W-1:0] mixed_seconds();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return SEC_W'($urandom);
            9:             return SEC_W'($urandom_range(MAX_SECONDS - 200000, MAX_SECONDS));
            default:       return edge_seconds();
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Offer one seconds count, optionally after an idle burst, and record the
    // date it should turn into once the transfer happens.
    task automatic send_seconds(input logic [SEC_W-1:0] secs);
        t_date_check entry;
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            sec_if.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        sec_if.valid <= 1'b1;
        sec_if.data.seconds_count <= secs;
        // Hold valid and data until the block takes them
        do @(posedge i_clk); while (!sec_if.ready);
        entry.secs = secs;
        entry.date = predict_date(secs);
        expected_dates.push_back(entry);
        n_sent++;
    endtask

    // Drop valid and hold until every owed date has come out
    task automatic wait_for_results();
        sec_if.valid <= 1'b0;
        do @(posedge i_clk); while (expected_dates.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Receiver side: random stalls, one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        int unsigned n;
        date_if.ready = 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (stall_request != 0) begin
                // Long hold-off: let the pipeline fill and push back on input
                n = stall_request;
                stall_request = 0;
                date_if.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
                date_if.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end else begin
                date_if.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result check
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want, input logic [SEC_W-1:0] secs);
        mismatches++;
        if (mismatches <= MAX_PRINTED) begin
            $display("mismatch %s at %0d s: got %0d, want %0d (cycle %0d)",
                     field, secs, got, want, cycles_run);
        end
    endtask

    always @(posedge i_clk) begin : date_monitor
        t_date_check want;
        if (i_rst_n && date_if.valid && date_if.ready) begin
            if (expected_dates.size() == 0) begin
                report_mismatch("unexpected date", 32'(date_if.data.year), '0, '0);
            end else begin
                want = expected_dates.pop_front();
                n_checked++;
                if (want.date.month == MONTH_DEC && want.date.day == DAY_LAST
                    && want.date.year[1:0] == 2'b00) begin
                    n_leap_year_end++;
                end
                if (want.date.month == 4'd2 && want.date.day == 5'd29) begin
                    n_feb29++;
                end
                if (date_if.data.year !== want.date.year)
                    report_mismatch("year", 32'(date_if.data.year),
                                    32'(want.date.year), want.secs);
                if (date_if.data.month !== want.date.month)
                    report_mismatch("month", 32'(date_if.data.month),
                                    32'(want.date.month), want.secs);
                if (date_if.data.day !== want.date.day)
                    report_mismatch("day", 32'(date_if.data.day),
                                    32'(want.date.day), want.secs);
                if (date_if.data.hour !== want.date.hour)
                    report_mismatch("hour", 32'(date_if.data.hour),
                                    32'(want.date.hour), want.secs);
                if (date_if.data.minute !== want.date.minute)
                    report_mismatch("minute", 32'(date_if.data.minute),
                                    32'(want.date.minute), want.secs);
                if (date_if.data.second !== want.date.second)
                    report_mismatch("second", 32'(date_if.data.second),
                                    32'(want.date.second), want.secs);
            end
        end
    end

    // Watchdog: end the run if the block hangs or drops a result
    always @(posedge i_clk) begin
        cycles_run <= cycles_run + 1;
        if (cycles_run == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d dates still owed",
                     cycles_run, expected_dates.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Rollovers of every field, both Februaries, the leap-year end and the
    // extremes of the input range.
    task automatic test_directed();
        send_seconds('0);
        send_seconds(day_secs(0, 59));
        send_seconds(day_secs(0, 60));
        send_seconds(day_secs(0, 3599));
        send_seconds(day_secs(0, 3600));
        send_seconds(day_secs(0, SEC_PER_DAY - 1));
        send_seconds(day_secs(1, 0));
        // February 28 to March 1 in a common year
        send_seconds(day_secs(58, SEC_PER_DAY - 1));
        send_seconds(day_secs(59, 0));
        // Common year end
        send_seconds(day_secs(364, SEC_PER_DAY - 1));
        send_seconds(day_secs(365, 0));
        // February 28, February 29 and March 1 of the leap year
        send_seconds(day_secs(3 * YEAR_DAYS + 58, 0));
        send_seconds(day_secs(3 * YEAR_DAYS + 59, 43200));
        send_seconds(day_secs(3 * YEAR_DAYS + 60, 0));
        // Last day of a four-year cycle and the start of the next one
        send_seconds(day_secs(LAST_DAY - 1, SEC_PER_DAY - 1));
        send_seconds(day_secs(LAST_DAY, 0));
        send_seconds(day_secs(LAST_DAY, SEC_PER_DAY - 1));
        send_seconds(day_secs(CYCLE_DAYS, 0));
        send_seconds(day_secs(LAST_FULL_CYCLE * CYCLE_DAYS + LAST_DAY, 0));
        // Top of the range and alternating bit patterns
        send_seconds(MAX_SECONDS);
        send_seconds(31'h2AAA_AAAA);
        send_seconds(31'h5555_5555);
        wait_for_results();
    endtask

    // Broad random traffic with idling on both channels
    task automatic test_random_traffic(input int unsigned count);
        repeat (count) send_seconds(mixed_seconds());
        wait_for_results();
    endtask

    // Hold the output off for a long stretch while input keeps coming, so the
    // pipeline fills and stalls its input; then pause until it drains.
    task automatic test_output_stall(input int unsigned count);
        src_idle_en = 1'b0;
        stall_request = HOLD_OFF_CYCLES;
        repeat (count) send_seconds(mixed_seconds());
        src_idle_en = 1'b1;
        wait_for_results();
    endtask

    // Month boundaries and cycle ends with random times of day
    task automatic test_calendar_edges(input int unsigned count);
        repeat (count) send_seconds(edge_seconds());
        wait_for_results();
    endtask

    // Full rate on both channels to finish the run
    task automatic test_back_to_back(input int unsigned count);
        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        repeat (count) send_seconds(mixed_seconds());
        wait_for_results();
    endtask

    initial begin
        i_rst_n = 1'b0;
        sec_if.valid = 1'b0;
        sec_if.data = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_traffic(900);
        test_output_stall(60);
        test_calendar_edges(400);
        test_back_to_back(400);

        // Let any stray output show up before the verdict
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("converted %0d seconds counts, checked %0d dates in %0d cycles",
                 n_sent, n_checked, cycles_run);
        $display("leap-year December 31 seen %0d times, February 29 seen %0d times",
                 n_leap_year_end, n_feb29);
        if (mismatches == 0 && expected_dates.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
